// ----- rtl/ccr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccr_pkg - shared definitions for the concentric circle rasteriser
// Coordinate and decision widths, stream layouts, request codes and the
// fixed octant colour table.
// ----------------------------------------------------------------------------
package ccr_pkg;

	// coordinate width of centre, radius, ring count and loop variables
	localparam int CW = 11;
	// decision variable width (signed)
	localparam int DEC_W = CW + 3;
	// output pixel coordinate width (signed, wraps)
	localparam int PIX_W = 13;
	localparam int COLOR_W = 24;
	// working width for pixel sums before wrapping to PIX_W
	localparam int PIX_CALC_W = (CW + 2 > PIX_W) ? CW + 2 : PIX_W;

	// stream data widths, padded to whole bytes
	localparam int IN_FIELDS_W = 4 * CW;
	localparam int IN_DATA_W = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 2 * PIX_W + COLOR_W;
	localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic signed [DEC_W-1:0] DEC_ONE = DEC_W'(1);

	// request kind carried in tuser
	localparam logic REQ_ADVANCE = 1'b0;
	localparam logic REQ_START = 1'b1;

	// number of pixels per iteration minus one
	localparam logic [2:0] LAST_PIX = 3'd7;

	// iteration snapshot handed to the pixel emitter
	typedef struct packed {
		logic [CW-1:0] cx;
		logic [CW-1:0] cy;
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic          done;
	} pix_ctx_t;

	// fixed colour of each octant pixel, in emission order
	function automatic logic [COLOR_W-1:0] pix_color(input logic [2:0] idx);
		logic [COLOR_W-1:0] c;
		unique case (idx)
			3'd0: c = 24'hFF0000;
			3'd1: c = 24'hF9429E;
			3'd2: c = 24'hFFFFFF;
			3'd3: c = 24'hF9429E;
			3'd4: c = 24'hFFFFFF;
			3'd5: c = 24'hF9FF9C;
			3'd6: c = 24'h0000FF;
			3'd7: c = 24'h00FF00;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/concentric_circle_rasterizer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// concentric_circle_rasterizer_top - nested ring circle rasteriser
// Andres-style circle stepping over a sequence of shrinking rings.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis carries requests. tuser = 1 starts a drawing: tdata gives the
//  centre, the outer radius and the number of further inner rings. A start
//  produces no pixels and restarts any drawing in progress. tuser = 0 runs
//  one iteration of the current ring; while idle it is dropped silently.
//  m_axis carries pixels: eight per iteration, tlast on the eighth, tuser
//  on the eighth pixel of the final iteration of the whole drawing.
// Ordering and throughput:
//  an advance transaction updates the loop state in the cycle it is taken
//  and loads the emitter snapshot; its pixels then pass through the output
//  register to m_axis, one pixel each cycle while m_axis_tready is high.
//  The pixel emitter (one octant per cycle unless stalled) sets the rate;
//  starts and idle advances are taken while it is free, and the next
//  transaction is taken as the current eighth pixel enters the output register.
// Reset: arst_n clears all loop state; the block comes up idle and empty.
// Stall: when m_axis_tready is low the output register holds its pixel,
//  the emitter waits and s_axis_tready stays low until the eighth pixel of
//  the iteration has entered the output register.
// ----------------------------------------------------------------------------
module concentric_circle_rasterizer_top (
	input  logic                           clk,
	input  logic                           arst_n,
	// request stream
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// center_x, center_y, radius, ring_count (lowest first), zero padded
	input  logic [ccr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// req_type
	input  logic                           s_axis_tuser,
	// pixel stream
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// pixel_x, pixel_y, color (lowest first), zero padded
	output logic [ccr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// last_of_step
	output logic                           m_axis_tlast,
	// drawing_done
	output logic                           m_axis_tuser
);

	localparam int CW = ccr_pkg::CW;
	localparam int DEC_W = ccr_pkg::DEC_W;
	localparam int PIX_W = ccr_pkg::PIX_W;
	localparam int PCW = ccr_pkg::PIX_CALC_W;
	localparam int COLOR_W = ccr_pkg::COLOR_W;
	localparam int OUT_PAD_W = ccr_pkg::OUT_DATA_W - ccr_pkg::OUT_FIELDS_W;

	// loop state
	logic [CW-1:0]           step_x_q;
	logic [CW-1:0]           step_y_q;
	logic signed [DEC_W-1:0] decision_q;
	logic [CW-1:0]           ring_radius_q;
	logic [CW-1:0]           rings_left_q;
	logic [CW-1:0]           origin_x_q;
	logic [CW-1:0]           origin_y_q;
	logic                    active_q;

	// pixel emitter
	ccr_pkg::pix_ctx_t ctx_q;
	logic              ctx_valid_q;
	logic [2:0]        pix_idx_q;

	// output register
	logic                    out_valid_q;
	logic [PIX_W-1:0]        out_px_q;
	logic [PIX_W-1:0]        out_py_q;
	logic [COLOR_W-1:0]      out_color_q;
	logic                    out_last_q;
	logic                    out_done_q;

	// request fields
	logic [CW-1:0] in_cx;
	logic [CW-1:0] in_cy;
	logic [CW-1:0] in_radius;
	logic [CW-1:0] in_rings;

	logic in_acc;
	logic start_go;
	logic adv_go;
	logic out_load;
	logic ctx_free;

	// iteration update
	logic signed [DEC_W-1:0] x_ext;
	logic signed [DEC_W-1:0] y_ext;
	logic signed [DEC_W-1:0] r_ext;
	logic signed [DEC_W-1:0] two_x;
	logic signed [DEC_W-1:0] two_ry;
	logic signed [DEC_W-1:0] d_new;
	logic signed [DEC_W-1:0] x_new;
	logic signed [DEC_W-1:0] y_new;
	logic                    ring_end;
	logic                    next_ring;
	logic [CW-1:0]           radius_dec;

	// pixel selection
	logic signed [PCW-1:0] cx_e;
	logic signed [PCW-1:0] cy_e;
	logic signed [PCW-1:0] x_e;
	logic signed [PCW-1:0] y_e;
	logic signed [PCW-1:0] px_sum;
	logic signed [PCW-1:0] py_sum;

	assign in_cx     = s_axis_tdata[CW-1:0];
	assign in_cy     = s_axis_tdata[2*CW-1:CW];
	assign in_radius = s_axis_tdata[3*CW-1:2*CW];
	assign in_rings  = s_axis_tdata[4*CW-1:3*CW];

	// handshake
	assign out_load      = ctx_valid_q && (!out_valid_q || m_axis_tready);
	assign ctx_free      = !ctx_valid_q || (out_load && (pix_idx_q == ccr_pkg::LAST_PIX));
	assign s_axis_tready = ctx_free;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign start_go      = in_acc && (s_axis_tuser == ccr_pkg::REQ_START);
	assign adv_go        = in_acc && (s_axis_tuser == ccr_pkg::REQ_ADVANCE) && active_q;

	// three-way update of d, x and y plus the end of ring test
	always_comb begin
		x_ext  = signed'(DEC_W'(step_x_q));
		y_ext  = signed'(DEC_W'(step_y_q));
		r_ext  = signed'(DEC_W'(ring_radius_q));
		two_x  = x_ext <<< 1;
		two_ry = (r_ext - y_ext) <<< 1;
		priority if (decision_q >= two_x) begin
			d_new = decision_q - two_x - ccr_pkg::DEC_ONE;
			x_new = x_ext + ccr_pkg::DEC_ONE;
			y_new = y_ext;
		end else if (decision_q < two_ry) begin
			d_new = decision_q + (y_ext <<< 1) - ccr_pkg::DEC_ONE;
			x_new = x_ext;
			y_new = y_ext - ccr_pkg::DEC_ONE;
		end else begin
			d_new = decision_q + ((y_ext - x_ext - ccr_pkg::DEC_ONE) <<< 1);
			x_new = x_ext + ccr_pkg::DEC_ONE;
			y_new = y_ext - ccr_pkg::DEC_ONE;
		end
		ring_end   = y_new < x_new;
		next_ring  = (ring_radius_q != '0) && (rings_left_q != '0);
		radius_dec = ring_radius_q - CW'(1);
	end

	// loop state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_x_q      <= '0;
			step_y_q      <= '0;
			decision_q    <= '0;
			ring_radius_q <= '0;
			rings_left_q  <= '0;
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			active_q      <= 1'b0;
		end else if (start_go) begin
			origin_x_q    <= in_cx;
			origin_y_q    <= in_cy;
			ring_radius_q <= in_radius;
			rings_left_q  <= in_rings;
			step_x_q      <= '0;
			step_y_q      <= in_radius;
			decision_q    <= signed'(DEC_W'(in_radius)) - ccr_pkg::DEC_ONE;
			active_q      <= 1'b1;
		end else if (adv_go) begin
			if (ring_end && next_ring) begin
				// start the next inner ring
				ring_radius_q <= radius_dec;
				rings_left_q  <= rings_left_q - CW'(1);
				step_x_q      <= '0;
				step_y_q      <= radius_dec;
				decision_q    <= signed'(DEC_W'(radius_dec)) - ccr_pkg::DEC_ONE;
			end else begin
				step_x_q   <= x_new[CW-1:0];
				step_y_q   <= y_new[CW-1:0];
				decision_q <= d_new;
				if (ring_end) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	// emitter control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_valid_q <= 1'b0;
			pix_idx_q   <= '0;
		end else if (adv_go) begin
			ctx_valid_q <= 1'b1;
			pix_idx_q   <= '0;
		end else if (out_load) begin
			pix_idx_q <= pix_idx_q + 3'd1;
			if (pix_idx_q == ccr_pkg::LAST_PIX) begin
				ctx_valid_q <= 1'b0;
			end
		end
	end

	// iteration snapshot (payload, no reset)
	always_ff @(posedge clk) begin
		if (adv_go) begin
			ctx_q.cx   <= origin_x_q;
			ctx_q.cy   <= origin_y_q;
			ctx_q.x    <= step_x_q;
			ctx_q.y    <= step_y_q;
			ctx_q.done <= ring_end && !next_ring;
		end
	end

	// octant pixel of the current index
	always_comb begin
		cx_e = signed'(PCW'(ctx_q.cx));
		cy_e = signed'(PCW'(ctx_q.cy));
		x_e  = signed'(PCW'(ctx_q.x));
		y_e  = signed'(PCW'(ctx_q.y));
		unique case (pix_idx_q)
			3'd0: begin px_sum = cx_e + x_e; py_sum = cy_e + y_e; end
			3'd1: begin px_sum = cx_e + y_e; py_sum = cy_e + x_e; end
			3'd2: begin px_sum = cx_e - x_e; py_sum = cy_e + y_e; end
			3'd3: begin px_sum = cx_e - y_e; py_sum = cy_e + x_e; end
			3'd4: begin px_sum = cx_e + x_e; py_sum = cy_e - y_e; end
			3'd5: begin px_sum = cx_e + y_e; py_sum = cy_e - x_e; end
			3'd6: begin px_sum = cx_e - x_e; py_sum = cy_e - y_e; end
			3'd7: begin px_sum = cx_e - y_e; py_sum = cy_e - x_e; end
			default: begin px_sum = '0; py_sum = '0; end
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_px_q    <= px_sum[PIX_W-1:0];
			out_py_q    <= py_sum[PIX_W-1:0];
			out_color_q <= ccr_pkg::pix_color(pix_idx_q);
			out_last_q  <= (pix_idx_q == ccr_pkg::LAST_PIX);
			out_done_q  <= (pix_idx_q == ccr_pkg::LAST_PIX) && ctx_q.done;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_color_q, out_py_q, out_px_q};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_done_q;

endmodule
